FILE: src/osp_pkg.sv
// Shared types and constants for the shortest-path parent finder.
package osp_pkg;

	localparam int NODE_W = 4;
	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] NODE_COUNT_RST = 5'd16;

	typedef struct packed {
		logic wt_we;
		logic dist_init;
		logic par_clear;
		logic du_fetch;
		logic du_load;
		logic relax;
		logic force_take;
		logic out_load;
		logic out_last;
	} osp_cmd_t;

endpackage

FILE: src/oblivious_shortest_path_parents_top.sv
// Top level of the shortest-path parent finder over an adjacency matrix.
// The block takes n*n edge weights in row-major order, one transfer per cycle, where n is the
// node_count register clamped to 1..MAX_NODES; writing node_count restarts the load at entry
// (0, 0). After the last weight it runs n full Bellman-Ford sweeps from node 0, taking ties as
// updates; every pair is read from the distance and weight memories in READ and then relaxed
// in RELAX, and each source row first fetches its own distance in FETCH_U. It then reports one
// parent per node in ascending node order, each result passing through EMIT_RD and EMIT_PUT,
// which waits while the output is stalled, with tlast on the highest node. The next load can
// start while the final result still waits in the output register.
module oblivious_shortest_path_parents_top #(
	parameter int MAX_NODES = 16,
	parameter int WEIGHT_BITS = 8,
	parameter int DIST_BITS = 16,
	localparam int IN_W = ((WEIGHT_BITS + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [osp_pkg::CNT_W-1:0]           cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// weight
	input  logic [IN_W-1:0]                     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// parent (upper half), node (lower half)
	output logic [2*osp_pkg::NODE_W-1:0]        m_tdata,
	output logic                                m_tlast
);
	import osp_pkg::*;

	localparam int NB = $clog2(MAX_NODES);

	osp_cmd_t          cmd;
	logic [NB-1:0]     u_idx;
	logic [NB-1:0]     v_idx;
	logic [NODE_W-1:0] node;
	logic [NODE_W-1:0] parent;

	osp_ctrl #(
		.MAX_NODES (MAX_NODES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.u_idx     (u_idx),
		.v_idx     (v_idx)
	);

	osp_dpath #(
		.MAX_NODES   (MAX_NODES),
		.WEIGHT_BITS (WEIGHT_BITS),
		.DIST_BITS   (DIST_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.u_idx  (u_idx),
		.v_idx  (v_idx),
		.weight (s_tdata[WEIGHT_BITS-1:0]),
		.node   (node),
		.parent (parent),
		.last   (m_tlast)
	);

	assign m_tdata = {parent, node};

endmodule

FILE: src/osp_ctrl.sv
// Controller: load, sweep and emit sequencing for the shortest-path parent finder.
module osp_ctrl #(
	parameter int MAX_NODES = 16,
	localparam int NB = $clog2(MAX_NODES)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [osp_pkg::CNT_W-1:0]  cfg_wdata,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output osp_pkg::osp_cmd_t          cmd,
	output logic [NB-1:0]              u_idx,
	output logic [NB-1:0]              v_idx
);
	import osp_pkg::*;

	typedef enum logic [2:0] {
		LOAD,
		INIT,
		FETCH_U,
		READ,
		RELAX,
		EMIT_RD,
		EMIT_PUT
	} state_t;

	state_t            state_q;
	logic [NB-1:0]     u_q;
	logic [NB-1:0]     v_q;
	logic [NB-1:0]     i_q;
	logic [CNT_W-1:0]  node_count_q;
	logic              m_tvalid_q;
	logic [NB-1:0]     nlast;
	logic              u_end;
	logic              v_end;
	logic              i_end;
	logic              s_accept;
	logic              put_ok;

	always_comb begin
		if (node_count_q == '0) begin
			nlast = '0;
		end else if (32'(node_count_q) > 32'(MAX_NODES)) begin
			nlast = NB'(MAX_NODES - 1);
		end else begin
			nlast = NB'(node_count_q - 5'd1);
		end
	end

	assign u_end    = (u_q == nlast);
	assign v_end    = (v_q == nlast);
	assign i_end    = (i_q == nlast);
	assign s_tready = (state_q == LOAD);
	assign s_accept = s_tvalid && s_tready;
	assign put_ok   = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign u_idx    = u_q;
	assign v_idx    = v_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			LOAD: begin
				cmd.wt_we = s_accept;
			end
			INIT: begin
				cmd.dist_init = 1'b1;
				cmd.par_clear = 1'b1;
			end
			FETCH_U: begin
				cmd.du_fetch = 1'b1;
			end
			READ: begin
				cmd.du_load = (v_q == '0);
			end
			RELAX: begin
				cmd.relax      = 1'b1;
				cmd.force_take = (i_q == '0) && (u_q == '0) && (v_q != '0);
			end
			EMIT_PUT: begin
				cmd.out_load = put_ok;
				cmd.out_last = v_end;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= LOAD;
			u_q          <= '0;
			v_q          <= '0;
			i_q          <= '0;
			node_count_q <= NODE_COUNT_RST;
			m_tvalid_q   <= 1'b0;
		end else begin
			if ((state_q == EMIT_PUT) && put_ok) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
				u_q          <= '0;
				v_q          <= '0;
				i_q          <= '0;
			end else begin
				case (state_q)
					LOAD: begin
						if (s_accept) begin
							if (v_end) begin
								v_q <= '0;
								if (u_end) begin
									u_q     <= '0;
									i_q     <= '0;
									state_q <= INIT;
								end else begin
									u_q <= u_q + NB'(1);
								end
							end else begin
								v_q <= v_q + NB'(1);
							end
						end
					end
					INIT: begin
						state_q <= FETCH_U;
					end
					FETCH_U: begin
						state_q <= READ;
					end
					READ: begin
						state_q <= RELAX;
					end
					RELAX: begin
						if (v_end) begin
							v_q <= '0;
							if (u_end) begin
								u_q <= '0;
								if (i_end) begin
									i_q     <= '0;
									state_q <= EMIT_RD;
								end else begin
									i_q     <= i_q + NB'(1);
									state_q <= FETCH_U;
								end
							end else begin
								u_q     <= u_q + NB'(1);
								state_q <= FETCH_U;
							end
						end else begin
							v_q     <= v_q + NB'(1);
							state_q <= READ;
						end
					end
					EMIT_RD: begin
						state_q <= EMIT_PUT;
					end
					EMIT_PUT: begin
						if (put_ok) begin
							if (v_end) begin
								v_q     <= '0;
								state_q <= LOAD;
							end else begin
								v_q     <= v_q + NB'(1);
								state_q <= EMIT_RD;
							end
						end
					end
					default: begin
						state_q <= LOAD;
					end
				endcase
			end
		end
	end

	a_relax_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == RELAX |-> $past(state_q) == READ)
		else $error("relaxation without a preceding read");

	a_init_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == INIT |-> $past(state_q) == LOAD)
		else $error("sweep started outside of a load");

	a_valid_from_put: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == EMIT_PUT)
		else $error("result presented outside of the emit phase");

	a_index_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> (u_q <= nlast) && (v_q <= nlast) && (i_q <= nlast))
		else $error("node index beyond the active node count");

endmodule

FILE: src/osp_dpath.sv
// Datapath: weight and distance memories, relaxation arithmetic and result register.
module osp_dpath #(
	parameter int MAX_NODES = 16,
	parameter int WEIGHT_BITS = 8,
	parameter int DIST_BITS = 16,
	localparam int NB = $clog2(MAX_NODES)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  osp_pkg::osp_cmd_t           cmd,
	input  logic [NB-1:0]               u_idx,
	input  logic [NB-1:0]               v_idx,
	input  logic [WEIGHT_BITS-1:0]      weight,
	output logic [osp_pkg::NODE_W-1:0]  node,
	output logic [osp_pkg::NODE_W-1:0]  parent,
	output logic                        last
);
	import osp_pkg::*;

	localparam int AW = 2 * NB;
	localparam int WT_DEPTH = 1 << AW;
	localparam int SUM_W = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;

	logic [WEIGHT_BITS-1:0] wt_mem [WT_DEPTH];
	logic [DIST_BITS-1:0]   dist_mem [MAX_NODES];
	logic [NODE_W-1:0]      par_mem [MAX_NODES];
	logic [MAX_NODES-1:0]   par_vld_q;

	logic [WEIGHT_BITS-1:0] wt_rd_q;
	logic [DIST_BITS-1:0]   dist_rd_q;
	logic [NODE_W-1:0]      par_rd_q;
	logic                   vld_rd_q;
	logic [DIST_BITS-1:0]   du_q;
	logic [NODE_W-1:0]      node_q;
	logic [NODE_W-1:0]      parent_q;
	logic                   last_q;

	logic [NB-1:0]          dist_addr;
	logic [SUM_W-1:0]       sum_full;
	logic [DIST_BITS-1:0]   sum_sat;
	logic                   take;
	logic                   dist_we;

	assign dist_addr = cmd.du_fetch ? u_idx : v_idx;
	assign sum_full  = SUM_W'(du_q) + SUM_W'(wt_rd_q);
	assign sum_sat   = (|sum_full[SUM_W-1:DIST_BITS]) ? '1 : sum_full[DIST_BITS-1:0];
	assign take      = cmd.force_take || (dist_rd_q >= sum_sat);
	assign dist_we   = cmd.relax && take;

	always_ff @(posedge clk) begin
		if (cmd.wt_we) begin
			wt_mem[{u_idx, v_idx}] <= weight;
		end
		wt_rd_q <= wt_mem[{u_idx, v_idx}];
	end

	always_ff @(posedge clk) begin
		if (cmd.dist_init) begin
			dist_mem[0] <= '0;
		end else if (dist_we) begin
			dist_mem[v_idx] <= sum_sat;
		end
		dist_rd_q <= dist_mem[dist_addr];
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			par_mem[v_idx] <= NODE_W'(u_idx);
		end
		par_rd_q <= par_mem[v_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_vld_q <= '0;
		end else if (cmd.par_clear) begin
			par_vld_q <= '0;
		end else if (dist_we) begin
			par_vld_q[v_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		vld_rd_q <= par_vld_q[v_idx];
		if (cmd.du_load) begin
			du_q <= dist_rd_q;
		end
		if (cmd.out_load) begin
			node_q   <= NODE_W'(v_idx);
			parent_q <= vld_rd_q ? par_rd_q : NODE_W'(1);
			last_q   <= cmd.out_last;
		end
	end

	assign node   = node_q;
	assign parent = parent_q;
	assign last   = last_q;

endmodule
